[rtl/edge_span_stepper_top_macros.svh]
// Assertion macros for the edge span stepper top level.
// Expects clk and rst in the scope where a macro is used.
`ifndef EDGE_SPAN_STEPPER_TOP_MACROS_SVH
`define EDGE_SPAN_STEPPER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define ESS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge span stepper: same-cycle check failed");

// Next-cycle implication, off during reset.
`define ESS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge span stepper: next-cycle check failed");

`endif

[rtl/ess_pkg.sv]
// Shared types and constants of the edge span stepper.
// No dependencies; ess_ctrl and the top level import it.
package ess_pkg;

  localparam int ESS_COORD_BITS = 16;
  localparam int ESS_SW_BITS    = 15;
  localparam logic [ESS_SW_BITS-1:0] ESS_SW_RESET = 15'd640;

  localparam logic ESS_ACT_START   = 1'b0;
  localparam logic ESS_ACT_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DX,
    S_DY,
    S_SEED,
    S_TRAIL,
    S_UPD,
    S_LEAD,
    S_YFIN,
    S_CLAMP,
    S_DONE
  } ess_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DX,
    OP_DY,
    OP_SEED,
    OP_TRAIL,
    OP_XSTEP,
    OP_XJUMP,
    OP_LEAD,
    OP_YSTEP,
    OP_YFIN,
    OP_CLAMP
  } ess_op_t;

  typedef struct packed {
    logic    load_in;
    ess_op_t op;
    logic    out_load;
  } ess_ctrl_t;

  typedef struct packed {
    logic is_start;
    logic xmajor;
    logic dy_zero;
    logic err_gt_dy;
  } ess_stat_t;

endpackage

[rtl/ess_in_if.sv]
// Input channel of the edge span stepper: one command item per handshake.
// Depends on nothing; width follows the coordinate parameter.
interface ess_in_if #(
  parameter int CB = 16
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic signed [CB-1:0] start_x;
  logic signed [CB-1:0] start_y;
  logic signed [CB-1:0] end_x;
  logic signed [CB-1:0] end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

[rtl/ess_out_if.sv]
// Output channel of the edge span stepper: one span item per handshake.
// Depends on nothing; width follows the coordinate parameter.
interface ess_out_if #(
  parameter int CB = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] span_left;
  logic signed [CB-1:0] span_right;
  logic signed [CB-1:0] edge_x;

  modport source (output valid, span_left, span_right, edge_x, input ready);
  modport sink   (input valid, span_left, span_right, edge_x, output ready);
endinterface

[rtl/ess_coord_alu.sv]
// Shared coordinate adder: a +/- b with full sum and saturated result.
// Uses no package items.
module ess_coord_alu #(
  parameter int CB = 16
) (
  input  logic signed [CB:0]   a,
  input  logic signed [CB:0]   b,
  input  logic                 sub,
  output logic signed [CB+1:0] sum,
  output logic signed [CB-1:0] sat
);
  logic signed [CB+1:0] ae;
  logic signed [CB+1:0] be;
  logic                 ovf;

  assign ae  = {a[CB], a};
  assign be  = {b[CB], b};
  assign sum = sub ? (ae - be) : (ae + be);

  // out of range when the three top bits disagree
  assign ovf = (sum[CB+1:CB-1] != 3'b000) && (sum[CB+1:CB-1] != 3'b111);

  always_comb begin
    if (!ovf) begin
      sat = sum[CB-1:0];
    end else if (sum[CB+1]) begin
      sat = {1'b1, {(CB-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CB-1){1'b1}}};
    end
  end
endmodule

[rtl/ess_err_alu.sv]
// Shared error term adder: err +/- one doubled delta.
// Uses no package items.
module ess_err_alu #(
  parameter int EW = 19,
  parameter int DW = 17
) (
  input  logic signed [EW-1:0] err,
  input  logic        [DW-1:0] opnd,
  input  logic                 sub,
  output logic signed [EW-1:0] res
);
  logic signed [EW-1:0] ext;

  assign ext = signed'({{(EW-DW){1'b0}}, opnd});
  assign res = sub ? (err - ext) : (err + ext);
endmodule

[rtl/ess_ctrl.sv]
// Sequencer of the edge span stepper: walks one item through its steps.
// Depends on ess_pkg for states, operation codes and control structs.
module ess_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ess_pkg::ess_stat_t stat,
  output logic              in_ready,
  output ess_pkg::ess_ctrl_t ctl
);
  import ess_pkg::*;

  ess_state_t state;
  ess_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    ctl.load_in  = 1'b0;
    ctl.op       = OP_NONE;
    ctl.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = (in_action == ESS_ACT_START) ? S_DX : S_TRAIL;
        end
      end
      S_DX: begin
        ctl.op     = OP_DX;
        state_next = S_DY;
      end
      S_DY: begin
        ctl.op     = OP_DY;
        state_next = S_SEED;
      end
      S_SEED: begin
        ctl.op     = OP_SEED;
        state_next = S_UPD;
      end
      S_TRAIL: begin
        ctl.op     = stat.xmajor ? OP_TRAIL : OP_NONE;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (stat.xmajor) begin
          if (!stat.err_gt_dy) begin
            state_next = S_LEAD;
          end else if (stat.dy_zero) begin
            // horizontal edge: jump the whole run at once
            ctl.op     = OP_XJUMP;
            state_next = S_LEAD;
          end else begin
            ctl.op = OP_XSTEP;
          end
        end else begin
          ctl.op     = OP_YSTEP;
          state_next = S_YFIN;
        end
      end
      S_LEAD: begin
        ctl.op     = OP_LEAD;
        state_next = stat.is_start ? S_DONE : S_CLAMP;
      end
      S_YFIN: begin
        ctl.op     = OP_YFIN;
        state_next = stat.is_start ? S_DONE : S_CLAMP;
      end
      S_CLAMP: begin
        ctl.op     = OP_CLAMP;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

[rtl/edge_span_stepper_top.sv]
// Edge span stepper top level: state registers, operand selection, output register.
// Depends on ess_pkg, ess_in_if, ess_out_if, ess_coord_alu, ess_err_alu, ess_ctrl.
//
// Each command item gives one span item. A start item loads an edge from its two
// endpoints; an advance item walks it down one scanline and clamps x to the screen.
// Items are taken one at a time. A start item runs the DX, DY and SEED steps and
// an advance item the TRAIL step; each then makes n single pixel x steps, where n
// is their number on that scanline (zero for y-major and horizontal edges).
// The error-term loop makes one x step per cycle through the shared error and
// coordinate adders. A finished item sits in an output register, and the next
// command item is taken while it waits. The user must write the screen width
// register via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
`include "edge_span_stepper_top_macros.svh"

module edge_span_stepper_top #(
  parameter int COORD_BITS = ess_pkg::ESS_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ess_pkg::ESS_SW_BITS-1:0]  cfg_wr_data,
  ess_in_if.sink                           edge_cmd,
  ess_out_if.source                        span
);
  import ess_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int EW = CB + 3;
  localparam int CW = ((CB > ESS_SW_BITS) ? CB : ESS_SW_BITS) + 1;

  logic [ESS_SW_BITS-1:0] screen_width;
  logic signed [1:0]      x_step;
  logic [DW-1:0]          double_dx;
  logic [DW-1:0]          double_dy;
  logic signed [EW-1:0]   error_term;
  logic signed [CB-1:0]   cur_x;
  logic signed [CB-1:0]   left_bound;
  logic signed [CB-1:0]   right_bound;

  logic                   act;
  logic signed [CB-1:0]   x1;
  logic signed [CB-1:0]   y1;
  logic signed [CB-1:0]   x2;
  logic signed [CB-1:0]   y2;

  logic                   out_valid;
  logic signed [CB-1:0]   out_left;
  logic signed [CB-1:0]   out_right;
  logic signed [CB-1:0]   out_x;

  ess_ctrl_t ctl;
  ess_stat_t stat;

  logic                   x_neg;
  logic                   x_pos;
  logic                   x_nz;

  logic signed [CB:0]     c_a;
  logic signed [CB:0]     c_b;
  logic                   c_sub;
  logic signed [CB+1:0]   c_sum;
  logic signed [CB-1:0]   c_sat;
  logic                   c_neg;
  logic signed [CB+1:0]   c_mag;
  logic [DW-1:0]          dd;

  logic [DW-1:0]          e_opnd;
  logic                   e_sub;
  logic signed [EW-1:0]   e_res;

  logic [DW-1:0]          d_max;
  logic signed [EW-1:0]   seed;
  logic signed [EW-1:0]   ddy_e;
  logic                   err_le_zero;
  logic signed [CW-1:0]   cur_cx;
  logic signed [CW-1:0]   sw_cx;
  logic                   over;
  logic                   under;

  assign x_neg = x_step[1];
  assign x_nz  = |x_step;
  assign x_pos = x_nz && !x_step[1];

  // status toward the sequencer
  assign ddy_e          = signed'({2'b00, double_dy});
  assign stat.is_start  = (act == ESS_ACT_START);
  assign stat.xmajor    = (double_dx > double_dy);
  assign stat.dy_zero   = (double_dy == '0);
  assign stat.err_gt_dy = (error_term > ddy_e);
  assign err_le_zero    = error_term[EW-1] || (error_term == '0);

  ess_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edge_cmd.valid),
    .in_action (edge_cmd.action),
    .out_valid (out_valid),
    .out_ready (span.ready),
    .stat      (stat),
    .in_ready  (edge_cmd.ready),
    .ctl       (ctl)
  );

  // operand selection for the two shared adders
  always_comb begin
    c_a    = {cur_x[CB-1], cur_x};
    c_b    = {{CB{1'b0}}, 1'b1};
    c_sub  = x_neg;
    e_opnd = double_dy;
    e_sub  = 1'b0;
    unique case (ctl.op)
      OP_DX: begin
        c_a   = {x2[CB-1], x2};
        c_b   = {x1[CB-1], x1};
        c_sub = 1'b1;
      end
      OP_DY: begin
        c_a   = {y2[CB-1], y2};
        c_b   = {y1[CB-1], y1};
        c_sub = 1'b1;
      end
      OP_XSTEP: begin
        e_sub = 1'b1;
      end
      OP_XJUMP: begin
        c_b = {1'b0, double_dx[DW-1:1]};
      end
      OP_LEAD: begin
        e_opnd = double_dx;
      end
      OP_YSTEP: begin
        c_b = {{CB{1'b0}}, x_nz};
      end
      OP_YFIN: begin
        e_opnd = double_dx;
        e_sub  = 1'b1;
      end
      OP_NONE, OP_SEED, OP_TRAIL, OP_CLAMP: begin
      end
      default: begin
      end
    endcase
  end

  ess_coord_alu #(.CB(CB)) u_coord (
    .a   (c_a),
    .b   (c_b),
    .sub (c_sub),
    .sum (c_sum),
    .sat (c_sat)
  );

  ess_err_alu #(.EW(EW), .DW(DW)) u_err (
    .err  (error_term),
    .opnd (e_opnd),
    .sub  (e_sub),
    .res  (e_res)
  );

  assign c_neg = c_sum[CB+1];
  assign c_mag = c_neg ? -c_sum : c_sum;
  assign dd    = {c_mag[CB-1:0], 1'b0};

  assign d_max = (double_dx > double_dy) ? double_dx : double_dy;
  assign seed  = signed'({3'b000, d_max[DW-1:1]});

  assign cur_cx = {{(CW-CB){cur_x[CB-1]}}, cur_x};
  assign sw_cx  = signed'({{(CW-ESS_SW_BITS){1'b0}}, screen_width});
  assign over   = x_pos && (cur_cx > sw_cx);
  assign under  = x_neg && cur_x[CB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= ESS_SW_RESET;
      x_step       <= '0;
      double_dx    <= '0;
      double_dy    <= '0;
      error_term   <= '0;
      cur_x        <= '0;
      left_bound   <= '0;
      right_bound  <= '0;
    end else begin
      if (cfg_wr_en) begin
        screen_width <= cfg_wr_data;
      end
      unique case (ctl.op)
        OP_DX: begin
          x_step      <= c_neg ? 2'sb11 : ((c_sum == '0) ? 2'sb00 : 2'sb01);
          double_dx   <= dd;
          cur_x       <= x1;
          left_bound  <= x1;
          right_bound <= x1;
        end
        OP_DY: begin
          double_dy <= dd;
        end
        OP_SEED: begin
          error_term <= seed;
        end
        OP_TRAIL: begin
          if (x_neg) begin
            right_bound <= c_sat;
          end else begin
            left_bound <= c_sat;
          end
        end
        OP_XSTEP: begin
          error_term <= e_res;
          cur_x      <= c_sat;
        end
        OP_XJUMP: begin
          cur_x <= c_sat;
        end
        OP_LEAD: begin
          if (x_neg) begin
            left_bound <= cur_x;
          end else begin
            right_bound <= cur_x;
          end
          // a horizontal edge only needs the error to stay positive
          if (!stat.dy_zero) begin
            error_term <= e_res;
          end
        end
        OP_YSTEP: begin
          if (err_le_zero) begin
            cur_x      <= c_sat;
            error_term <= e_res;
          end
        end
        OP_YFIN: begin
          left_bound  <= cur_x;
          right_bound <= cur_x;
          error_term  <= e_res;
        end
        OP_CLAMP: begin
          if (over) begin
            cur_x <= sw_cx[CB-1:0];
          end else if (under) begin
            cur_x <= '0;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // command payload, captured on accept
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      act <= edge_cmd.action;
      x1  <= edge_cmd.start_x;
      y1  <= edge_cmd.start_y;
      x2  <= edge_cmd.end_x;
      y2  <= edge_cmd.end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (span.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_left  <= left_bound;
      out_right <= right_bound;
      out_x     <= cur_x;
    end
  end

  assign span.valid      = out_valid;
  assign span.span_left  = out_left;
  assign span.span_right = out_right;
  assign span.edge_x     = out_x;

  `ESS_ASSERT_NEXT(a_busy_after_accept, edge_cmd.valid && edge_cmd.ready, !edge_cmd.ready)
  `ESS_ASSERT_IMPL(a_xmajor_has_dir, stat.xmajor, x_step != 2'sb00)
  `ESS_ASSERT_IMPL(a_no_overwrite, ctl.out_load, !out_valid || span.ready)
  `ESS_ASSERT_IMPL(a_step_needs_err, ctl.op == OP_XSTEP, stat.err_gt_dy && !stat.dy_zero)

endmodule
